// File: hw/rtl/sstf_disk_request_scheduler_macros.svh
// Assertion macros for the SSTF disk request scheduler.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef SSTF_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset
`define SSTF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sstf assertion failed");
// Next-cycle implication, disabled while in reset
`define SSTF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sstf assertion failed");
`else
`define SSTF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SSTF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/sstf_pkg.sv
// Shared types, constants and helpers for the SSTF disk request scheduler.
// No dependencies.
`timescale 1ns / 1ps

package sstf_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int CYL_BITS    = 16;
   localparam int IDX_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS    = 21;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [CYL_BITS-1:0] request_cylinder;
      logic [CYL_BITS-1:0] start_head;
   } req_type;

   typedef struct packed {
      logic [CYL_BITS-1:0] from_cylinder;
      logic [CYL_BITS-1:0] to_cylinder;
      logic [CYL_BITS-1:0] move_distance;
      logic [SUM_BITS-1:0] total_movement;
      logic                move_valid;
      logic                last;
   } rsp_type;

   // best-so-far candidate travelling down the cell chain
   typedef struct packed {
      logic                tok;
      logic                found;
      logic [CYL_BITS-1:0] seek;
      logic [IDX_BITS-1:0] idx;
      logic [CYL_BITS-1:0] cyl;
   } cand_type;

   // per-cell control strobes
   typedef struct packed {
      logic wr_en;
      logic serve;
      logic clear;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   function automatic logic [CYL_BITS-1:0] abs_diff(input logic [CYL_BITS-1:0] a,
                                                    input logic [CYL_BITS-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

// File: hw/rtl/sstf_cell.sv
// One request cell: holds a cylinder and its valid/served bits, and folds
// itself into the nearest-request candidate passing through. Uses sstf_pkg.
`timescale 1ns / 1ps

module sstf_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  sstf_pkg::cell_ctl_type         ctl,
   input  logic [sstf_pkg::IDX_BITS-1:0]  cell_idx,
   input  logic [sstf_pkg::CYL_BITS-1:0]  wr_cyl,
   input  logic [sstf_pkg::CYL_BITS-1:0]  head,
   input  sstf_pkg::cand_type             up_cand,
   output sstf_pkg::cand_type             dn_cand
);

   logic [sstf_pkg::CYL_BITS-1:0] cyl_ff;
   logic                          used_ff;
   logic                          served_ff;
   sstf_pkg::cand_type            cand_ff;
   sstf_pkg::cand_type            cand_in;
   logic [sstf_pkg::CYL_BITS-1:0] seek_len;
   logic                          take;

   // compare own distance against the best so far; strict less keeps
   // the lower index on a tie
   always_comb begin
      seek_len = sstf_pkg::abs_diff(cyl_ff, head);
      take     = used_ff && !served_ff && (!up_cand.found || (seek_len < up_cand.seek));
      cand_in  = up_cand;
      if (take) begin
         cand_in.found = 1'b1;
         cand_in.seek  = seek_len;
         cand_in.idx   = cell_idx;
         cand_in.cyl   = cyl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff <= cand_in;
      end
   end

   // entry state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= 1'b0;
         served_ff <= 1'b0;
      end else if (ctl.clear) begin
         used_ff   <= 1'b0;
         served_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            used_ff <= 1'b1;
         end
         if (ctl.serve) begin
            served_ff <= 1'b1;
         end
      end
   end

   // stored cylinder, no reset
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         cyl_ff <= wr_cyl;
      end
   end

   assign dn_cand = cand_ff;

endmodule

// File: hw/rtl/sstf_disk_request_scheduler.sv
// SSTF disk request scheduler top level: sequencer plus a chain of QUEUE_DEPTH cells.
// Each pick sends a search token down the cell chain, through each cell's register,
// then emits the nearest unserved request; a run holds off input from the run word
// until its last result is emitted. An empty run gives a single result word.
// rsp_stall can hold a result back until the output register is free.
// Reset (synchronous) empties the store and clears the sequencer and output valid.
// Uses sstf_pkg, sstf_cell and sstf_disk_request_scheduler_macros.svh.
`timescale 1ns / 1ps
`include "sstf_disk_request_scheduler_macros.svh"

module sstf_disk_request_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sstf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sstf_pkg::rsp_type rsp_data
);

   sstf_pkg::state_type           state_ff, state_in;
   logic [sstf_pkg::CNT_BITS-1:0] count_ff;
   logic [sstf_pkg::CNT_BITS-1:0] step_ff;
   logic [sstf_pkg::CYL_BITS-1:0] head_ff;
   logic [sstf_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   sstf_pkg::cand_type            pick_ff;
   logic                          rsp_valid_ff;
   sstf_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   sstf_pkg::cand_type            chain [sstf_pkg::QUEUE_DEPTH+1];
   sstf_pkg::cell_ctl_type        ctl   [sstf_pkg::QUEUE_DEPTH];
   sstf_pkg::cand_type            tail_cand;

   logic req_acc, load_en, run_en, start_en, emit_en, empty_en, out_free, is_last;
   logic [sstf_pkg::SUM_BITS:0] sum_wide;

   assign tail_cand = chain[sstf_pkg::QUEUE_DEPTH];

   // ---------------- sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sstf_pkg::ST_IDLE: begin
            if (run_en) begin
               state_in = (count_ff == '0) ? sstf_pkg::ST_EMPTY : sstf_pkg::ST_START;
            end
         end
         sstf_pkg::ST_START: state_in = sstf_pkg::ST_SCAN;
         sstf_pkg::ST_SCAN: begin
            if (tail_cand.tok) begin
               state_in = sstf_pkg::ST_EMIT;
            end
         end
         sstf_pkg::ST_EMIT: begin
            if (emit_en) begin
               state_in = is_last ? sstf_pkg::ST_IDLE : sstf_pkg::ST_START;
            end
         end
         sstf_pkg::ST_EMPTY: begin
            if (empty_en) begin
               state_in = sstf_pkg::ST_IDLE;
            end
         end
         default: state_in = sstf_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (state_ff != sstf_pkg::ST_IDLE);
      req_acc   = req_valid && !req_stall;
      load_en   = req_acc && (req_data.cmd == sstf_pkg::CMD_LOAD) &&
                  (count_ff < sstf_pkg::CNT_BITS'(sstf_pkg::QUEUE_DEPTH));
      run_en    = req_acc && (req_data.cmd == sstf_pkg::CMD_RUN);
      start_en  = (state_ff == sstf_pkg::ST_START);
      emit_en   = (state_ff == sstf_pkg::ST_EMIT) && out_free;
      empty_en  = (state_ff == sstf_pkg::ST_EMPTY) && out_free;
      is_last   = ((step_ff + sstf_pkg::CNT_BITS'(1)) == count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sstf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- run bookkeeping
   always_comb begin
      sum_wide = {1'b0, sum_ff} + (sstf_pkg::SUM_BITS+1)'(pick_ff.seek);
      sum_in   = sum_wide[sstf_pkg::SUM_BITS] ? sstf_pkg::SUM_MAX
                                              : sum_wide[sstf_pkg::SUM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         step_ff  <= '0;
         head_ff  <= '0;
         sum_ff   <= '0;
      end else begin
         if (load_en) begin
            count_ff <= count_ff + sstf_pkg::CNT_BITS'(1);
         end
         if (run_en) begin
            head_ff <= req_data.start_head;
            sum_ff  <= '0;
            step_ff <= '0;
         end
         if (emit_en) begin
            head_ff <= pick_ff.cyl;
            sum_ff  <= sum_in;
            step_ff <= step_ff + sstf_pkg::CNT_BITS'(1);
            if (is_last) begin
               count_ff <= '0;
            end
         end
      end
   end

   // winner capture at the chain tail
   always_ff @(posedge clock) begin
      if ((state_ff == sstf_pkg::ST_SCAN) && tail_cand.tok) begin
         pick_ff <= tail_cand;
      end
   end

   // ---------------- cell chain
   assign chain[0] = '{tok: start_en, found: 1'b0, seek: '0, idx: '0, cyl: '0};

   for (genvar g = 0; g < sstf_pkg::QUEUE_DEPTH; g++) begin : g_cell
      always_comb begin
         ctl[g].wr_en = load_en &&
                        (count_ff[sstf_pkg::IDX_BITS-1:0] == sstf_pkg::IDX_BITS'(g));
         ctl[g].serve = emit_en && (pick_ff.idx == sstf_pkg::IDX_BITS'(g));
         ctl[g].clear = emit_en && is_last;
      end

      sstf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl[g]),
         .cell_idx (sstf_pkg::IDX_BITS'(g)),
         .wr_cyl   (req_data.request_cylinder),
         .head     (head_ff),
         .up_cand  (chain[g]),
         .dn_cand  (chain[g+1])
      );
   end

   // ---------------- result register
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (emit_en) begin
         rsp_data_in.from_cylinder  = head_ff;
         rsp_data_in.to_cylinder    = pick_ff.cyl;
         rsp_data_in.move_distance  = pick_ff.seek;
         rsp_data_in.total_movement = sum_in;
         rsp_data_in.move_valid     = 1'b1;
         rsp_data_in.last           = is_last;
      end else if (empty_en) begin
         rsp_data_in.from_cylinder  = head_ff;
         rsp_data_in.to_cylinder    = head_ff;
         rsp_data_in.move_distance  = '0;
         rsp_data_in.total_movement = '0;
         rsp_data_in.move_valid     = 1'b0;
         rsp_data_in.last           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_en || empty_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- checks
   // a search token only reaches the tail while the sequencer waits for it
   `SSTF_ASSERT_IMP(a_tok_in_scan, clock, reset, tail_cand.tok, state_ff == sstf_pkg::ST_SCAN)
   // every search finds an unserved request
   `SSTF_ASSERT_IMP(a_tok_found, clock, reset, tail_cand.tok, tail_cand.found)
   // picks never run past the loaded count
   `SSTF_ASSERT_IMP(a_step_bound, clock, reset, state_ff == sstf_pkg::ST_EMIT, step_ff < count_ff)
   // a final pick leaves the store empty
   `SSTF_ASSERT_NXT(a_last_clears, clock, reset, emit_en && is_last, count_ff == '0)

endmodule

// File: tb/sv/sstf_move_checker.sv
// Move checker for the SSTF disk request scheduler: watches both word channels,
// predicts every head move from the accepted request words and compares.
// Depends on sstf_pkg for the word types, sizes and command codes.
`timescale 1ns / 1ps

module sstf_move_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  sstf_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  sstf_pkg::rsp_type rsp_data,
   output int                expected_left,
   output int                fail_count
);

   localparam int SHOW_MAX = 10;

   // shadow copy of the request store
   logic [sstf_pkg::CYL_BITS-1:0] queued_cyl [sstf_pkg::QUEUE_DEPTH];
   int                            queued_count;
   sstf_pkg::rsp_type             expected_moves [$];
   int                            errors;

   // replay one run: nearest unserved request first, lowest index on a tie
   task automatic schedule_moves(input logic [sstf_pkg::CYL_BITS-1:0] start);
      logic [sstf_pkg::CYL_BITS-1:0]    head;
      logic [sstf_pkg::CYL_BITS-1:0]    seek_len;
      logic [sstf_pkg::CYL_BITS-1:0]    best_seek;
      bit   [sstf_pkg::QUEUE_DEPTH-1:0] served;
      int unsigned                      total;
      int                               best;
      sstf_pkg::rsp_type                mv;
      head   = start;
      served = '0;
      total  = 0;
      if (queued_count == 0) begin
         // empty run: one word, no move
         mv.from_cylinder  = start;
         mv.to_cylinder    = start;
         mv.move_distance  = '0;
         mv.total_movement = '0;
         mv.move_valid     = 1'b0;
         mv.last           = 1'b1;
         expected_moves    = {expected_moves, mv};
      end
      for (int step = 0; step < queued_count; step++) begin
         best      = -1;
         best_seek = '0;
         for (int j = 0; j < queued_count; j++) begin
            if (!served[j]) begin
               seek_len = (queued_cyl[j] >= head) ? queued_cyl[j] - head
                                                  : head - queued_cyl[j];
               if (best < 0 || seek_len < best_seek) begin
                  best      = j;
                  best_seek = seek_len;
               end
            end
         end
         served[best] = 1'b1;
         total = total + best_seek;
         if (total > sstf_pkg::SUM_MAX)
            total = sstf_pkg::SUM_MAX;
         mv.from_cylinder  = head;
         mv.to_cylinder    = queued_cyl[best];
         mv.move_distance  = best_seek;
         mv.total_movement = total[sstf_pkg::SUM_BITS-1:0];
         mv.move_valid     = 1'b1;
         mv.last           = (step + 1 == queued_count);
         expected_moves    = {expected_moves, mv};
         head = queued_cyl[best];
      end
      queued_count = 0;
   endtask

   // compare one result word against the oldest expected move
   task automatic check_move(input sstf_pkg::rsp_type got);
      sstf_pkg::rsp_type want;
      bit                bad;
      if (expected_moves.size() == 0) begin
         errors++;
         if (errors <= SHOW_MAX)
            $display("%0t: unexpected move word: from %0d to %0d dist %0d",
                     $realtime, got.from_cylinder, got.to_cylinder, got.move_distance,
                     " total %0d valid %0b last %0b",
                     got.total_movement, got.move_valid, got.last);
      end else begin
         want = expected_moves.pop_front();
         bad  = (got.from_cylinder  !== want.from_cylinder)
              | (got.to_cylinder    !== want.to_cylinder)
              | (got.move_distance  !== want.move_distance)
              | (got.total_movement !== want.total_movement)
              | (got.move_valid     !== want.move_valid)
              | (got.last           !== want.last);
         if (bad) begin
            errors++;
            if (errors <= SHOW_MAX)
               $display("%0t: move mismatch: expected from %0d to %0d dist %0d",
                        $realtime, want.from_cylinder, want.to_cylinder,
                        want.move_distance,
                        " total %0d valid %0b last %0b;",
                        want.total_movement, want.move_valid, want.last,
                        " got from %0d to %0d dist %0d",
                        got.from_cylinder, got.to_cylinder, got.move_distance,
                        " total %0d valid %0b last %0b",
                        got.total_movement, got.move_valid, got.last);
         end
      end
   endtask

   // results are checked before the same edge's request word is predicted
   always @(posedge clock) begin
      if (reset) begin
         expected_moves.delete();
         queued_count = 0;
         errors       = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_move(rsp_data);
         if (req_valid && !req_stall) begin
            if (req_data.cmd == sstf_pkg::CMD_LOAD) begin
               // a load into a full store is dropped
               if (queued_count < sstf_pkg::QUEUE_DEPTH) begin
                  queued_cyl[queued_count] = req_data.request_cylinder;
                  queued_count++;
               end
            end else begin
               schedule_moves(req_data.start_head);
            end
         end
      end
      expected_left <= expected_moves.size();
      fail_count    <= errors;
   end

endmodule

// File: tb/sv/tb_top.sv
// Top of the SSTF disk request scheduler bench: clock, reset, request words and
// result stall; the verdict comes from sstf_move_checker. Depends on sstf_pkg.
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT   = 5000;
   localparam int PICK_CYCLES  = sstf_pkg::QUEUE_DEPTH + 3;
   localparam int RANDOM_WORDS = 130;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sstf_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sstf_pkg::rsp_type rsp_data;

   int expected_left;
   int fail_total;
   int words_sent = 0;
   int idle_cycles = 0;
   bit burst_mode = 1'b0;

   sstf_disk_request_scheduler uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sstf_move_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .expected_left (expected_left),
      .fail_count    (fail_total)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // extremes, clusters around a center (ties, duplicates) or anything
   function automatic logic [sstf_pkg::CYL_BITS-1:0] pick_cylinder(
         input logic [sstf_pkg::CYL_BITS-1:0] center);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return '0;
      if (r < 10)
         return '1;
      if (r < 40)
         return center + sstf_pkg::CYL_BITS'($urandom_range(0, 8))
                - sstf_pkg::CYL_BITS'(4);
      return sstf_pkg::CYL_BITS'($urandom_range(0, 65535));
   endfunction

   // loads before a run: mostly few, some up to a full store, rarely past it
   function automatic int pick_run_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return $urandom_range(1, 6);
      if (r < 88)
         return $urandom_range(7, 20);
      if (r < 96)
         return $urandom_range(21, sstf_pkg::QUEUE_DEPTH);
      return $urandom_range(sstf_pkg::QUEUE_DEPTH + 1, sstf_pkg::QUEUE_DEPTH + 4);
   endfunction

   // drive one request word and hold it until accepted
   task automatic send_word(input logic cmd, input logic [sstf_pkg::CYL_BITS-1:0] cyl,
                            input logic [sstf_pkg::CYL_BITS-1:0] head);
      sstf_pkg::req_type w;
      int                gap;
      w.cmd              = cmd;
      w.request_cylinder = (cmd == sstf_pkg::CMD_LOAD) ? cyl
                           : sstf_pkg::CYL_BITS'($urandom_range(0, 65535));
      w.start_head       = (cmd == sstf_pkg::CMD_RUN) ? head
                           : sstf_pkg::CYL_BITS'($urandom_range(0, 65535));
      gap = burst_mode ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // sender holds off until every expected move has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_left != 0)
         @(negedge clock);
   endtask

   // result-side stall: random stretches, none in burst mode
   always @(negedge clock) begin : stall_gen
      static int hold_left = 0;
      static bit holding   = 1'b0;
      if (hold_left > 0) begin
         hold_left--;
      end else begin
         holding   = ($urandom_range(0, 2) == 0);
         hold_left = holding ? pick_gap() : $urandom_range(0, 6);
      end
      rsp_stall <= holding && !burst_mode;
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin : stimulus
      int                            seq_no;
      int                            n;
      logic [sstf_pkg::CYL_BITS-1:0] center;
      seq_no = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: empty runs at both head extremes
      send_word(sstf_pkg::CMD_RUN, '0, '0);
      send_word(sstf_pkg::CMD_RUN, '0, '1);
      // single request at the top cylinder, head at zero
      send_word(sstf_pkg::CMD_LOAD, '1, '0);
      send_word(sstf_pkg::CMD_RUN, '0, '0);
      wait_drained();
      // extremes around mid-travel
      send_word(sstf_pkg::CMD_LOAD, '0, '0);
      send_word(sstf_pkg::CMD_LOAD, '1, '0);
      send_word(sstf_pkg::CMD_LOAD, 16'd32768, '0);
      send_word(sstf_pkg::CMD_RUN, '0, 16'd32768);
      // equal distance both ways and a duplicate cylinder
      send_word(sstf_pkg::CMD_LOAD, 16'd110, '0);
      send_word(sstf_pkg::CMD_LOAD, 16'd90, '0);
      send_word(sstf_pkg::CMD_LOAD, 16'd90, '0);
      send_word(sstf_pkg::CMD_LOAD, 16'd100, '0);
      send_word(sstf_pkg::CMD_RUN, '0, 16'd100);
      wait_drained();

      // random: mostly load bursts closed by a run, some lone noise words
      while (words_sent < RANDOM_WORDS) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         center     = sstf_pkg::CYL_BITS'($urandom_range(0, 65535));
         if (seq_no > 1 && $urandom_range(0, 9) == 0) begin
            send_word(1'($urandom_range(0, 1)), pick_cylinder(center),
                      pick_cylinder(center));
         end else begin
            // first sequence overfills the store so a dropped load is seen
            n = (seq_no == 0) ? sstf_pkg::QUEUE_DEPTH + 2 : pick_run_length();
            repeat (n)
               send_word(sstf_pkg::CMD_LOAD, pick_cylinder(center), '0);
            send_word(sstf_pkg::CMD_RUN, '0, pick_cylinder(center));
         end
         if ($urandom_range(0, 7) == 0)
            wait_drained();
         seq_no++;
      end
      burst_mode = 1'b0;
      send_word(sstf_pkg::CMD_RUN, '0, pick_cylinder(center));

      // drain, then wait for stray words before the verdict
      wait_drained();
      repeat (2 * PICK_CYCLES) @(negedge clock);
      if (fail_total == 0 && expected_left == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// File: sstf_disk_request_scheduler.f
+incdir+hw/rtl
hw/rtl/sstf_pkg.sv
hw/rtl/sstf_cell.sv
hw/rtl/sstf_disk_request_scheduler.sv
tb/sv/sstf_move_checker.sv
tb/sv/tb_top.sv
